// ===== rtl/ckrb_pkg.sv =====
`default_nettype none

package ckrb_pkg;

	// Field widths fixed by the register map and the pixel format
	localparam int PIX_W      = 8;
	localparam int POS_W      = 12;
	localparam int DIM_W      = 13;
	localparam int MODE_W     = 2;
	localparam int OUT_ADDR_W = 24;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = REG_IDX_W + 2;

	// Register indexes (byte address is 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_RASTER_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_COLOR    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FILL_COLOR   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RECT_X       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RECT_Y       = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RECT_W       = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_RECT_H       = 3'd7;

	// Raster operation codes
	localparam logic [MODE_W-1:0] MODE_COPY   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_KEYED  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MONO   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_INVERT = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] raster_mode;
		logic [PIX_W-1:0]  key_color;
		logic [PIX_W-1:0]  fill_color;
		logic [DIM_W-1:0]  screen_width;
		logic [POS_W-1:0]  rect_x;
		logic [POS_W-1:0]  rect_y;
		logic [DIM_W-1:0]  rect_w;
		logic [DIM_W-1:0]  rect_h;
	} cfg_t;

	typedef struct packed {
		logic [OUT_ADDR_W-1:0] pixel_address;
		logic                  last_pixel;
	} loc_t;

	typedef struct packed {
		logic [PIX_W-1:0] write_pixel;
		logic             write_enable;
	} rop_res_t;

endpackage

`default_nettype wire

// ===== rtl/ckrb_regs.sv =====
`default_nettype none

module ckrb_regs
	import ckrb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output cfg_t                    cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx   = paddr[PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Write the addressed register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{raster_mode: MODE_COPY, key_color: '0, fill_color: '0,
			           screen_width: DIM_W'(1), rect_x: '0, rect_y: '0,
			           rect_w: DIM_W'(1), rect_h: DIM_W'(1)};
		end else if (wr_en) begin
			case (idx)
				REG_RASTER_MODE:  cfg_q.raster_mode  <= pwdata[MODE_W-1:0];
				REG_KEY_COLOR:    cfg_q.key_color    <= pwdata[PIX_W-1:0];
				REG_FILL_COLOR:   cfg_q.fill_color   <= pwdata[PIX_W-1:0];
				REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[DIM_W-1:0];
				REG_RECT_X:       cfg_q.rect_x       <= pwdata[POS_W-1:0];
				REG_RECT_Y:       cfg_q.rect_y       <= pwdata[POS_W-1:0];
				REG_RECT_W:       cfg_q.rect_w       <= pwdata[DIM_W-1:0];
				REG_RECT_H:       cfg_q.rect_h       <= pwdata[DIM_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			REG_RASTER_MODE:  prdata = PDATA_W'(cfg_q.raster_mode);
			REG_KEY_COLOR:    prdata = PDATA_W'(cfg_q.key_color);
			REG_FILL_COLOR:   prdata = PDATA_W'(cfg_q.fill_color);
			REG_SCREEN_WIDTH: prdata = PDATA_W'(cfg_q.screen_width);
			REG_RECT_X:       prdata = PDATA_W'(cfg_q.rect_x);
			REG_RECT_Y:       prdata = PDATA_W'(cfg_q.rect_y);
			REG_RECT_W:       prdata = PDATA_W'(cfg_q.rect_w);
			REG_RECT_H:       prdata = PDATA_W'(cfg_q.rect_h);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ckrb_addr_gen.sv =====
`default_nettype none

module ckrb_addr_gen
	import ckrb_pkg::*;
#(
	parameter int MAX_DIM   = 4096,
	parameter int ADDR_BITS = 24
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic step,
	output loc_t      loc
);

	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int PROD_W = POS_W + DIM_W;
	localparam int SUM_W  = PROD_W + 1;

	logic [CNT_W-1:0]     col_q;
	logic [CNT_W-1:0]     row_q;
	logic [ADDR_BITS-1:0] row_base_q;
	logic [ADDR_BITS-1:0] start_base_q;

	logic [PROD_W-1:0]    prod;
	logic [SUM_W-1:0]     origin;
	logic                 w_big;
	logic                 h_big;
	logic [CNT_W-1:0]     w_last;
	logic [CNT_W-1:0]     h_last;
	logic                 at_start;
	logic [ADDR_BITS-1:0] cur_base;
	logic [ADDR_BITS-1:0] addr_full;
	logic                 end_col;
	logic                 end_row;

	// Rectangle origin offset; the user must change registers only while idle
	// (not enforced by the block), so the registered product is settled before any item reaches this stage
	assign prod   = PROD_W'(cfg.rect_y) * PROD_W'(cfg.screen_width);
	assign origin = SUM_W'(prod) + SUM_W'(cfg.rect_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_base_q <= '0;
		end else begin
			start_base_q <= ADDR_BITS'(origin);
		end
	end

	// Zero or oversized extents count as the full range
	assign w_big  = (cfg.rect_w == '0) || (32'(cfg.rect_w) > MAX_DIM);
	assign h_big  = (cfg.rect_h == '0) || (32'(cfg.rect_h) > MAX_DIM);
	assign w_last = w_big ? CNT_W'(MAX_DIM - 1) : CNT_W'(cfg.rect_w - DIM_W'(1));
	assign h_last = h_big ? CNT_W'(MAX_DIM - 1) : CNT_W'(cfg.rect_h - DIM_W'(1));

	// Current pixel position
	assign at_start  = (col_q == '0) && (row_q == '0);
	assign cur_base  = at_start ? start_base_q : row_base_q;
	assign addr_full = cur_base + ADDR_BITS'(col_q);
	assign end_col   = (col_q >= w_last);
	assign end_row   = (row_q >= h_last);

	assign loc.pixel_address = OUT_ADDR_W'(addr_full);
	assign loc.last_pixel    = end_col && end_row;

	// Advance the raster walk once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
		end else if (step) begin
			if (end_col) begin
				col_q <= '0;
				if (end_row) begin
					row_q      <= '0;
					row_base_q <= cur_base;
				end else begin
					row_q      <= row_q + CNT_W'(1);
					row_base_q <= cur_base + ADDR_BITS'(cfg.screen_width);
				end
			end else begin
				col_q      <= col_q + CNT_W'(1);
				row_base_q <= cur_base;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ckrb_rop.sv =====
`default_nettype none

module ckrb_rop
	import ckrb_pkg::*;
(
	input  wire cfg_t             cfg,
	input  wire logic [PIX_W-1:0] src_pixel,
	input  wire logic [PIX_W-1:0] dst_pixel,
	output rop_res_t              res
);

	logic not_key;

	assign not_key = (src_pixel != cfg.key_color);

	// Select the stored pixel; a skipped write carries the old pixel
	always_comb begin
		case (cfg.raster_mode)
			MODE_COPY: begin
				res.write_pixel  = src_pixel;
				res.write_enable = 1'b1;
			end
			MODE_KEYED: begin
				res.write_pixel  = not_key ? src_pixel : dst_pixel;
				res.write_enable = not_key;
			end
			MODE_MONO: begin
				res.write_pixel  = not_key ? cfg.fill_color : dst_pixel;
				res.write_enable = not_key;
			end
			MODE_INVERT: begin
				res.write_pixel  = ~dst_pixel;
				res.write_enable = 1'b1;
			end
			default: begin
				res.write_pixel  = src_pixel;
				res.write_enable = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/color_key_rect_blitter_top.sv =====
// Rectangle raster-operation engine: takes one source/destination pixel pair
// per item in row-major order over the configured rectangle and returns the
// framebuffer address, the pixel to store, its write enable and a last-pixel
// mark. An item is accepted every clock cycle while results are taken; it is
// held in the input register until the result register is free or being
// taken, and its result is then loaded there and shown on the ports. A full
// result register that is not taken stalls intake after one more item.
// The rectangle origin product is registered from the configuration; an item
// accepted at the first edge after a register write already sees the new value.
`default_nettype none

module color_key_rect_blitter_top
	import ckrb_pkg::*;
#(
	parameter int MAX_DIM   = 4096,
	parameter int ADDR_BITS = 24
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic      [PDATA_W-1:0]    prdata,
	output logic                       pready,
	// pixel items
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic [PIX_W-1:0]      src_pixel,
	input  wire logic [PIX_W-1:0]      dst_pixel,
	// results
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic      [OUT_ADDR_W-1:0] pixel_address,
	output logic      [PIX_W-1:0]      write_pixel,
	output logic                       write_enable,
	output logic                       last_pixel
);

	cfg_t             cfg;
	loc_t             loc;
	rop_res_t         rop_res;

	logic             valid_s1;
	logic [PIX_W-1:0] src_s1;
	logic [PIX_W-1:0] dst_s1;
	logic             valid_s2;
	logic             advance;

	assign pready = 1'b1;

	ckrb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Move the item from the input register to the result register
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			src_s1 <= src_pixel;
			dst_s1 <= dst_pixel;
		end
	end

	ckrb_addr_gen #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_addr_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.loc    (loc)
	);

	ckrb_rop u_rop (
		.cfg       (cfg),
		.src_pixel (src_s1),
		.dst_pixel (dst_s1),
		.res       (rop_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_address <= loc.pixel_address;
			last_pixel    <= loc.last_pixel;
			write_pixel   <= rop_res.write_pixel;
			write_enable  <= rop_res.write_enable;
		end
	end

	assign result_valid = valid_s2;

endmodule

`default_nettype wire

// ===== rtl/ckrb_checker.sv =====
`default_nettype none

module ckrb_checker
	import ckrb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pready,
	input  wire logic                  item_valid,
	input  wire logic                  item_ready,
	input  wire logic                  result_valid,
	input  wire logic                  result_ready,
	input  wire logic [OUT_ADDR_W-1:0] pixel_address,
	input  wire logic [PIX_W-1:0]      write_pixel,
	input  wire logic                  write_enable,
	input  wire logic                  last_pixel
);

	// A stalled result holds its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pixel_address)
			&& $stable(write_pixel) && $stable(write_enable) && $stable(last_pixel))
		else $error("stalled result changed");

	// With no result waiting, intake is open
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("intake closed with empty result register");

	// An accepted item shows up as a result after the input and result registers
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |-> ##2 result_valid)
		else $error("accepted item produced no result");

	// Configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind color_key_rect_blitter_top ckrb_checker u_ckrb_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ckrb_pkg::*;

	localparam int MAX_DIM         = 4096;
	localparam int ADDR_BITS       = 24;
	localparam int RANDOM_ITEMS    = 1100;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int SETTLE_CYCLES   = 10;
	localparam int CYCLE_LIMIT     = 600000;

	// One framebuffer write as the block reports it
	typedef struct packed {
		logic [OUT_ADDR_W-1:0] addr;
		logic [PIX_W-1:0]      pix;
		logic                  we;
		logic                  last;
	} blit_write_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_ready;
	logic [PIX_W-1:0]      src_pixel;
	logic [PIX_W-1:0]      dst_pixel;
	logic                  result_valid;
	logic                  result_ready;
	logic [OUT_ADDR_W-1:0] pixel_address;
	logic [PIX_W-1:0]      write_pixel;
	logic                  write_enable;
	logic                  last_pixel;

	// Register copy and rectangle walk state of the predictor
	cfg_t                  cfg_shadow;
	logic [POS_W-1:0]      col_pos;
	logic [POS_W-1:0]      row_pos;
	logic [OUT_ADDR_W-1:0] row_base;

	blit_write_t           expected_writes[$];
	blit_write_t           got_write;
	blit_write_t           want_write;

	int unsigned error_count;
	int unsigned items_sent;
	int unsigned items_accepted;
	int unsigned rect_ends;
	int unsigned skipped_writes;
	int unsigned reg_writes;
	int unsigned rect_phases;
	int unsigned cycle_count;
	int unsigned rx_stall;
	bit          rx_hold_req;
	bit          rx_burst;
	bit          tx_burst;

	color_key_rect_blitter_top #(
		.MAX_DIM  (MAX_DIM),
		.ADDR_BITS(ADDR_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.src_pixel    (src_pixel),
		.dst_pixel    (dst_pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_address(pixel_address),
		.write_pixel  (write_pixel),
		.write_enable (write_enable),
		.last_pixel   (last_pixel)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Zero or oversized extents count as the full dimension
	function automatic logic [DIM_W-1:0] extent_of(input logic [DIM_W-1:0] v);
		if (v == '0 || v > DIM_W'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		return v;
	endfunction

	// Compute the write for one pixel and advance the rectangle walk
	function automatic blit_write_t blit_pixel(input logic [PIX_W-1:0] s,
			input logic [PIX_W-1:0] d);
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [31:0]      origin;
		logic             end_col;
		logic             end_row;
		blit_write_t      r;
		w = extent_of(cfg_shadow.rect_w);
		h = extent_of(cfg_shadow.rect_h);
		if (col_pos == '0 && row_pos == '0) begin
			origin = 32'(cfg_shadow.rect_y) * 32'(cfg_shadow.screen_width)
				+ 32'(cfg_shadow.rect_x);
			row_base = origin[OUT_ADDR_W-1:0];
		end
		r.addr = row_base + OUT_ADDR_W'(col_pos);
		case (cfg_shadow.raster_mode)
			MODE_COPY: begin
				r.pix = s;
				r.we  = 1'b1;
			end
			MODE_KEYED: begin
				r.we  = (s != cfg_shadow.key_color);
				r.pix = r.we ? s : d;
			end
			MODE_MONO: begin
				r.we  = (s != cfg_shadow.key_color);
				r.pix = r.we ? cfg_shadow.fill_color : d;
			end
			default: begin
				r.pix = ~d;
				r.we  = 1'b1;
			end
		endcase
		end_col = ({1'b0, col_pos} >= w - 1'b1);
		end_row = ({1'b0, row_pos} >= h - 1'b1);
		r.last  = end_col && end_row;
		if (end_col) begin
			col_pos = '0;
			if (end_row) begin
				row_pos = '0;
			end else begin
				row_pos  = row_pos + 1'b1;
				row_base = row_base + OUT_ADDR_W'(cfg_shadow.screen_width);
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
		return r;
	endfunction

	// Predict on intake, check each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				expected_writes.push_back(blit_pixel(src_pixel, dst_pixel));
				items_accepted++;
			end
			if (result_valid && result_ready) begin
				got_write = {pixel_address, write_pixel, write_enable, last_pixel};
				if (expected_writes.size() == 0) begin
					if (error_count < 40)
						$display("%0t: unexpected result %h/%h/%b/%b",
							$time, got_write.addr, got_write.pix, got_write.we,
							got_write.last);
					error_count++;
				end else begin
					want_write = expected_writes.pop_front();
					if (got_write !== want_write) begin
						if (error_count < 40)
							$display("%0t: expected %h/%h/%b/%b actual %h/%h/%b/%b",
								$time, want_write.addr, want_write.pix, want_write.we,
								want_write.last, got_write.addr, got_write.pix,
								got_write.we, got_write.last);
						error_count++;
					end
					if (want_write.last)
						rect_ends++;
					if (!want_write.we)
						skipped_writes++;
				end
			end
		end
	end

	// Result side: random stalls, bursts without stalls, and a long hold-off on request
	initial begin
		int unsigned r;
		result_ready = 1'b0;
		rx_stall     = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_stall    = HOLD_OFF_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (rx_stall > 0) begin
				result_ready <= 1'b0;
				rx_stall--;
			end else begin
				result_ready <= 1'b1;
				if (!rx_burst) begin
					r = $urandom_range(0, 99);
					if (r < 15)
						rx_stall = $urandom_range(1, 3);
					else if (r < 18)
						rx_stall = $urandom_range(10, 40);
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Idle cycles before the next item: mostly none, some short, a few long
	function automatic int unsigned tx_gap();
		int unsigned r;
		if (tx_burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one pixel item and hold it until accepted
	task automatic send_pixel(input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] d,
			input int unsigned gap);
		logic ok;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		src_pixel  <= s;
		dst_pixel  <= d;
		do begin
			@(negedge clk);
			ok = item_ready;
			@(posedge clk);
		end while (!ok);
		items_sent++;
	endtask

	// Drop valid and wait until every predicted write has come back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_writes.size() != 0)
			@(posedge clk);
	endtask

	// Write one register through the configuration port and mirror it
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		logic ok;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			ok = pready;
			@(posedge clk);
		end while (!ok);
		case (idx)
			REG_RASTER_MODE:  cfg_shadow.raster_mode  = value[MODE_W-1:0];
			REG_KEY_COLOR:    cfg_shadow.key_color    = value[PIX_W-1:0];
			REG_FILL_COLOR:   cfg_shadow.fill_color   = value[PIX_W-1:0];
			REG_SCREEN_WIDTH: cfg_shadow.screen_width = value[DIM_W-1:0];
			REG_RECT_X:       cfg_shadow.rect_x       = value[POS_W-1:0];
			REG_RECT_Y:       cfg_shadow.rect_y       = value[POS_W-1:0];
			REG_RECT_W:       cfg_shadow.rect_w       = value[DIM_W-1:0];
			default:          cfg_shadow.rect_h       = value[DIM_W-1:0];
		endcase
		reg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Let the origin product settle before the next item
	task automatic settle_config();
		repeat (2) @(posedge clk);
	endtask

	// Set unused upper data bits now and then; the block must ignore them
	function automatic logic [PDATA_W-1:0] with_junk(input logic [PDATA_W-1:0] v,
			input int unsigned bits);
		if ($urandom_range(0, 3) == 0)
			return v | (PDATA_W'($urandom()) << bits);
		return v;
	endfunction

	function automatic logic [PDATA_W-1:0] pick_value(input int unsigned hi);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	// Mostly small extents, rarely one of the full-size encodings
	function automatic logic [PDATA_W-1:0] pick_extent(input int unsigned small_hi);
		if ($urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 3))
				0:       return 0;
				1:       return MAX_DIM;
				2:       return MAX_DIM + 1;
				default: return 8191;
			endcase
		end
		return $urandom_range(1, small_hi);
	endfunction

	// Defaults after reset: one-pixel rectangle at offset zero, plain copy
	task automatic test_reset_state();
		send_pixel(8'h00, 8'hFF, 0);
		send_pixel(8'hFF, 8'h00, 0);
		send_pixel(8'hA5, 8'h5A, 1);
		drain();
	endtask

	// Plain copy over a 3x2 rectangle with a row pitch
	task automatic test_copy();
		write_reg(REG_RASTER_MODE, PDATA_W'(MODE_COPY));
		write_reg(REG_SCREEN_WIDTH, 10);
		write_reg(REG_RECT_X, 5);
		write_reg(REG_RECT_Y, 2);
		write_reg(REG_RECT_W, 3);
		write_reg(REG_RECT_H, 2);
		settle_config();
		send_pixel(8'h00, 8'hFF, 0);
		send_pixel(8'hFF, 8'h00, 0);
		send_pixel(8'h55, 8'hAA, 0);
		send_pixel(8'hAA, 8'h55, 2);
		send_pixel(8'h01, 8'h80, 0);
		send_pixel(8'h80, 8'h01, 0);
		drain();
	endtask

	// Keyed copy: key pixels leave the destination value in place
	task automatic test_keyed_copy();
		write_reg(REG_RASTER_MODE, PDATA_W'(MODE_KEYED));
		write_reg(REG_KEY_COLOR, PDATA_W'(8'hFF));
		settle_config();
		send_pixel(8'hFF, 8'h12, 0);
		send_pixel(8'h00, 8'h34, 0);
		drain();
		write_reg(REG_KEY_COLOR, PDATA_W'(8'h00));
		settle_config();
		send_pixel(8'h00, 8'hC3, 0);
		send_pixel(8'hFF, 8'h3C, 0);
		drain();
	endtask

	// Mono fill of non-key pixels
	task automatic test_mono_fill();
		write_reg(REG_RASTER_MODE, PDATA_W'(MODE_MONO));
		write_reg(REG_KEY_COLOR, PDATA_W'(8'h3C));
		write_reg(REG_FILL_COLOR, PDATA_W'(8'hFF));
		settle_config();
		send_pixel(8'h3C, 8'h77, 0);
		send_pixel(8'h00, 8'h77, 0);
		drain();
		write_reg(REG_FILL_COLOR, PDATA_W'(8'h00));
		settle_config();
		send_pixel(8'hFF, 8'h99, 0);
		drain();
	endtask

	// Invert ignores the source pixel
	task automatic test_invert();
		write_reg(REG_RASTER_MODE, PDATA_W'(MODE_INVERT));
		settle_config();
		send_pixel(8'hFF, 8'h00, 0);
		send_pixel(8'h00, 8'hFF, 0);
		drain();
	endtask

	// Origin and row steps past the 24-bit address range, then a zero pitch
	task automatic test_address_wrap();
		write_reg(REG_RASTER_MODE, PDATA_W'(MODE_COPY));
		write_reg(REG_SCREEN_WIDTH, 8191);
		write_reg(REG_RECT_X, 4095);
		write_reg(REG_RECT_Y, 4095);
		write_reg(REG_RECT_W, 1);
		write_reg(REG_RECT_H, 3);
		settle_config();
		repeat (4) send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), 0);
		drain();
		write_reg(REG_SCREEN_WIDTH, 0);
		settle_config();
		repeat (2) send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), 0);
		drain();
	endtask

	// Zero and oversized extents act as the full dimension
	task automatic test_extent_limits();
		write_reg(REG_RECT_W, 0);
		write_reg(REG_RECT_H, 1);
		settle_config();
		send_pixel(8'h11, 8'h22, 0);
		send_pixel(8'h33, 8'h44, 0);
		drain();
		write_reg(REG_RECT_W, 8191);
		write_reg(REG_RECT_H, MAX_DIM + 1);
		settle_config();
		send_pixel(8'h55, 8'h66, 0);
		send_pixel(8'h77, 8'h88, 0);
		drain();
	endtask

	// Hold the result side off while items keep coming, so intake stalls
	task automatic test_backpressure();
		write_reg(REG_RECT_W, 4);
		write_reg(REG_RECT_H, 3);
		write_reg(REG_SCREEN_WIDTH, 64);
		settle_config();
		rx_hold_req = 1'b1;
		repeat (40) send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), 0);
		drain();
	endtask

	// Random rectangles under random settings, draining between settings
	task automatic test_random_rects();
		int unsigned     target;
		int unsigned     n;
		int unsigned     area;
		logic [PIX_W-1:0] s;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			drain();
			rx_burst = ($urandom_range(0, 4) == 0);
			tx_burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_RASTER_MODE, with_junk($urandom_range(0, 3), MODE_W));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_KEY_COLOR, with_junk(pick_value(255), PIX_W));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_FILL_COLOR, with_junk(pick_value(255), PIX_W));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SCREEN_WIDTH, with_junk(pick_value(8191), DIM_W));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_RECT_X, with_junk(pick_value(4095), POS_W));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_RECT_Y, with_junk(pick_value(4095), POS_W));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_RECT_W, with_junk(pick_extent(8), DIM_W));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_RECT_H, with_junk(pick_extent(6), DIM_W));
			settle_config();
			area = extent_of(cfg_shadow.rect_w) * extent_of(cfg_shadow.rect_h);
			if (area > 64)
				n = $urandom_range(10, 30);
			else
				n = area * $urandom_range(1, 3) + $urandom_range(0, 2);
			// hit the key often so suppressed writes are common
			repeat (n) begin
				s = ($urandom_range(0, 3) == 0) ? cfg_shadow.key_color : PIX_W'($urandom());
				send_pixel(s, PIX_W'($urandom()), tx_gap());
				if ($urandom_range(0, 199) == 0)
					drain();
			end
			rect_phases++;
		end
		rx_burst = 1'b0;
		tx_burst = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		item_valid  = 1'b0;
		src_pixel   = '0;
		dst_pixel   = '0;
		rx_hold_req = 1'b0;
		rx_burst    = 1'b0;
		tx_burst    = 1'b0;
		cycle_count = 0;
		cfg_shadow  = '{raster_mode: MODE_COPY, key_color: '0, fill_color: '0,
			screen_width: 1, rect_x: '0, rect_y: '0, rect_w: 1, rect_h: 1};
		col_pos     = '0;
		row_pos     = '0;
		row_base    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_copy();
		test_keyed_copy();
		test_mono_fill();
		test_invert();
		test_address_wrap();
		test_extent_limits();
		test_backpressure();
		test_random_rects();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("summary: %0d pixel items checked, %0d rectangle ends, %0d suppressed writes",
			items_accepted, rect_ends, skipped_writes);
		$display("summary: %0d register writes over %0d random settings, %0d mismatches",
			reg_writes, rect_phases, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
